// ===== rtl/bpts_pkg.sv =====
// ----------------------------------------------------------------------------
// Boosted priority thread scheduler package
// Field widths, command codes, the constants of the effective priority and the
// result type of the priority evaluation unit.
// ----------------------------------------------------------------------------
package bpts_pkg;

    localparam int CMD_W  = 2;
    localparam int PRIO_W = 32;
    localparam int PID_W  = 9;
    localparam int WIN_W  = 34;

    localparam logic [CMD_W-1:0] CMD_CREATE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TERMINATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SCHEDULE  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RESERVED  = 2'd3;

    localparam logic [PRIO_W-1:0] BOOST_LIMIT   = 32'd10;
    localparam logic [WIN_W-1:0]  FAIRNESS_TERM = 34'd1000000;

    typedef struct packed {
        logic             greater;
        logic [WIN_W-1:0] eff;
    } eval_res_t;

endpackage

// ===== rtl/bpts_eval.sv =====
// ----------------------------------------------------------------------------
// Priority evaluation unit
// Forms the effective priority of one table entry and compares it with the
// best value found so far in the scan.
// ----------------------------------------------------------------------------
module bpts_eval (
    input  logic [bpts_pkg::PRIO_W-1:0] prio,
    input  logic [bpts_pkg::WIN_W-1:0]  best,
    output bpts_pkg::eval_res_t         res
);

    logic [bpts_pkg::WIN_W-1:0] scaled;
    logic [bpts_pkg::WIN_W-1:0] eff;

    always_comb begin
        if (prio > bpts_pkg::BOOST_LIMIT) begin
            scaled = {1'b0, prio, 1'b0};
        end else begin
            scaled = {2'b00, prio};
        end
        eff         = scaled + bpts_pkg::FAIRNESS_TERM;
        res.eff     = eff;
        res.greater = (eff > best);
    end

endmodule

// ===== rtl/boosted_priority_thread_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// Boosted priority thread scheduler
// Thread table with create, terminate and highest-priority-first schedule.
//
//   Channel  Direction  Ports
//   s_       in         s_valid, s_ready, s_command, s_base_priority,
//                       s_target_pid
//   m_       out        m_valid, m_ready, m_new_pid, m_switched,
//                       m_running_pid, m_winning_priority
//   cfg_     in         cfg_wr_en, cfg_wr_data (scheduler_running)
//
// Create, terminate, unused codes and a schedule with the scheduler stopped or
// an empty table complete in the cycle of acceptance.
// A schedule that runs reads the priority memory once per filled slot through the
// single evaluation unit, then passes through drain and result.
// Reset is synchronous and clears the active marks, the counters and control.
// A new transaction is taken only when the result register is free or being
// emptied in the same cycle.
// ----------------------------------------------------------------------------
module boosted_priority_thread_scheduler_unit #(
    parameter int TABLE_DEPTH = 256
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bpts_pkg::CMD_W-1:0]    s_command,
    input  logic [bpts_pkg::PRIO_W-1:0]   s_base_priority,
    input  logic [bpts_pkg::PID_W-1:0]    s_target_pid,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bpts_pkg::PID_W-1:0]    m_new_pid,
    output logic                          m_switched,
    output logic [bpts_pkg::PID_W-1:0]    m_running_pid,
    output logic [bpts_pkg::WIN_W-1:0]    m_winning_priority
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CMP_W = (CNT_W > bpts_pkg::PID_W) ? CNT_W : bpts_pkg::PID_W;
    localparam int EXT_W = CNT_W + bpts_pkg::PID_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FINISH} state_t;

    state_t                        state_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              cur_reg;
    logic                          running_reg;
    logic [TABLE_DEPTH-1:0]        active_reg;
    logic [CNT_W-1:0]              scan_idx_reg;
    logic                          rd_vld_reg;
    logic                          rd_act_reg;
    logic [CNT_W-1:0]              rd_pid_reg;
    logic [bpts_pkg::PRIO_W-1:0]   rd_prio_reg;
    logic [bpts_pkg::WIN_W-1:0]    best_prio_reg;
    logic [CNT_W-1:0]              best_pid_reg;

    logic                          m_valid_reg;
    logic [bpts_pkg::PID_W-1:0]    m_new_pid_reg;
    logic                          m_switched_reg;
    logic [bpts_pkg::PID_W-1:0]    m_running_pid_reg;
    logic [bpts_pkg::WIN_W-1:0]    m_winning_priority_reg;

    logic [bpts_pkg::PRIO_W-1:0]   prio_mem [TABLE_DEPTH];

    logic                          s_fire;
    logic                          out_free;
    logic                          table_full;
    logic                          sched_go;
    logic                          res_load;
    logic                          term_ok;
    logic [CNT_W-1:0]              cnt_inc;
    logic [CMP_W-1:0]              tpid_cmp;
    logic [CMP_W-1:0]              term_idx_full;
    logic [IDX_W-1:0]              term_idx;
    logic [IDX_W-1:0]              fill_idx;
    logic [IDX_W-1:0]              scan_addr;
    logic [CNT_W-1:0]              fin_pid;
    logic [EXT_W-1:0]              new_ext;
    logic [EXT_W-1:0]              cur_ext;
    logic [EXT_W-1:0]              fin_ext;
    bpts_pkg::eval_res_t           eval_res;

    always_comb begin
        out_free      = !m_valid_reg || m_ready;
        s_ready       = (state_reg == ST_IDLE) && out_free;
        s_fire        = s_valid && s_ready;
        table_full    = (count_reg == CNT_W'(TABLE_DEPTH));
        sched_go      = running_reg && (count_reg != '0);
        res_load      = (s_fire && !((s_command == bpts_pkg::CMD_SCHEDULE) && sched_go))
                        || ((state_reg == ST_FINISH) && out_free);
        cnt_inc       = count_reg + 1'b1;
        tpid_cmp      = CMP_W'(s_target_pid);
        term_ok       = (tpid_cmp != '0) && (tpid_cmp <= CMP_W'(count_reg));
        term_idx_full = tpid_cmp - 1'b1;
        term_idx      = term_idx_full[IDX_W-1:0];
        fill_idx      = count_reg[IDX_W-1:0];
        scan_addr     = scan_idx_reg[IDX_W-1:0];
        fin_pid       = (best_pid_reg != '0) ? best_pid_reg : cur_reg;
        new_ext       = EXT_W'(cnt_inc);
        cur_ext       = EXT_W'(cur_reg);
        fin_ext       = EXT_W'(fin_pid);
    end

    bpts_eval u_eval (
        .prio (rd_prio_reg),
        .best (best_prio_reg),
        .res  (eval_res)
    );

    always_ff @(posedge aclk) begin
        if (s_fire && (s_command == bpts_pkg::CMD_CREATE) && !table_full) begin
            prio_mem[fill_idx] <= s_base_priority;
        end
        rd_prio_reg <= prio_mem[scan_addr];
        rd_act_reg  <= active_reg[scan_addr];
        rd_pid_reg  <= scan_idx_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            cur_reg     <= '0;
            running_reg <= 1'b0;
            active_reg  <= '0;
            rd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                running_reg <= cfg_wr_data;
            end
            if (res_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (rd_vld_reg && rd_act_reg && eval_res.greater) begin
                best_prio_reg <= eval_res.eff;
                best_pid_reg  <= rd_pid_reg;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        m_new_pid_reg          <= ((s_command == bpts_pkg::CMD_CREATE)
                                                   && !table_full)
                                                  ? new_ext[bpts_pkg::PID_W-1:0] : '0;
                        m_switched_reg         <= 1'b0;
                        m_winning_priority_reg <= '0;
                        m_running_pid_reg      <= cur_ext[bpts_pkg::PID_W-1:0];
                        case (s_command)
                            bpts_pkg::CMD_CREATE: begin
                                if (!table_full) begin
                                    active_reg[fill_idx] <= 1'b1;
                                    count_reg            <= cnt_inc;
                                end
                            end
                            bpts_pkg::CMD_TERMINATE: begin
                                if (term_ok) begin
                                    active_reg[term_idx] <= 1'b0;
                                end
                            end
                            bpts_pkg::CMD_SCHEDULE: begin
                                if (sched_go) begin
                                    state_reg     <= ST_SCAN;
                                    scan_idx_reg  <= '0;
                                    best_prio_reg <= '0;
                                    best_pid_reg  <= '0;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    scan_idx_reg <= scan_idx_reg + 1'b1;
                    if (scan_idx_reg == count_reg - 1'b1) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH: begin
                    if (out_free) begin
                        m_new_pid_reg     <= '0;
                        m_switched_reg    <= (best_pid_reg != '0) && (best_pid_reg != cur_reg);
                        m_running_pid_reg <= fin_ext[bpts_pkg::PID_W-1:0];
                        m_winning_priority_reg <= (best_pid_reg != '0) ? best_prio_reg : '0;
                        cur_reg           <= fin_pid;
                        state_reg         <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_new_pid          = m_new_pid_reg;
    assign m_switched         = m_switched_reg;
    assign m_running_pid      = m_running_pid_reg;
    assign m_winning_priority = m_winning_priority_reg;

endmodule

// ===== rtl/bpts_checker.sv =====
// ----------------------------------------------------------------------------
// Boosted priority thread scheduler checker
// Port-level checks on the result channel and on acceptance, bound to the top
// level.
// ----------------------------------------------------------------------------
module bpts_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [bpts_pkg::PID_W-1:0]  m_new_pid,
    input logic                        m_switched,
    input logic [bpts_pkg::WIN_W-1:0]  m_winning_priority
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid)
        else $error("result transaction withdrawn before it was taken");

    // A new transaction is only taken when the result register can hold its result.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (!m_valid || m_ready))
        else $error("transaction accepted while a result was stalled");

    // A switch always carries a winner whose priority includes the fairness term.
    a_switch_win: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_switched) |-> (m_winning_priority >= bpts_pkg::FAIRNESS_TERM))
        else $error("switch reported without a valid winning priority");

    // A created pid never comes with schedule results.
    a_create_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_new_pid != '0)) |-> (!m_switched && (m_winning_priority == '0)))
        else $error("create result mixed with schedule fields");

endmodule

bind boosted_priority_thread_scheduler_unit bpts_checker u_bpts_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_valid            (s_valid),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_new_pid          (m_new_pid),
    .m_switched         (m_switched),
    .m_winning_priority (m_winning_priority)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the boosted priority thread scheduler
// Directed and random create, terminate and schedule commands drive the unit
// through bursty input traffic and a stalling result side. A model of the
// thread table predicts each result, which is compared field by field.
// ----------------------------------------------------------------------------
module tb;

    localparam int TABLE_DEPTH = 256;
    localparam int HOLD_CYCLES = 1500;
    localparam int IDLE_LIMIT  = 20000;
    localparam int END_SETTLE  = 300;

    typedef struct packed {
        logic [bpts_pkg::CMD_W-1:0]  cmd;
        logic [bpts_pkg::PRIO_W-1:0] prio;
        logic [bpts_pkg::PID_W-1:0]  pid;
    } sched_cmd_t;

    typedef struct packed {
        logic [bpts_pkg::PID_W-1:0] new_pid;
        logic                       switched;
        logic [bpts_pkg::PID_W-1:0] running_pid;
        logic [bpts_pkg::WIN_W-1:0] win;
    } sched_result_t;

    logic                          aclk            = 1'b0;
    logic                          aresetn         = 1'b0;
    logic                          cfg_wr_en       = 1'b0;
    logic                          cfg_wr_data     = 1'b0;
    logic                          s_valid         = 1'b0;
    logic                          s_ready;
    logic [bpts_pkg::CMD_W-1:0]    s_command       = bpts_pkg::CMD_CREATE;
    logic [bpts_pkg::PRIO_W-1:0]   s_base_priority = '0;
    logic [bpts_pkg::PID_W-1:0]    s_target_pid    = '0;
    logic                          m_valid;
    logic                          m_ready         = 1'b0;
    logic [bpts_pkg::PID_W-1:0]    m_new_pid;
    logic                          m_switched;
    logic [bpts_pkg::PID_W-1:0]    m_running_pid;
    logic [bpts_pkg::WIN_W-1:0]    m_winning_priority;

    sched_cmd_t          pending_cmds[$];
    sched_result_t       expected_results[$];

    // Thread table as the unit should hold it.
    logic [bpts_pkg::PRIO_W-1:0] prio_table[TABLE_DEPTH];
    logic                live_mask[TABLE_DEPTH];
    int unsigned         threads_made    = 0;
    int unsigned         current_pid     = 0;
    logic                sched_enabled   = 1'b0;

    int unsigned         mismatches      = 0;
    int unsigned         idle_cycles     = 0;
    int unsigned         burst_left      = 1;
    int unsigned         gap_left        = 0;
    int unsigned         hold_left       = 0;
    int unsigned         results_taken   = 0;
    logic [7:0]          rx_cycle        = '0;
    int unsigned         gen_threads     = 0;
    logic [bpts_pkg::PRIO_W-1:0] last_prio = '0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    boosted_priority_thread_scheduler_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_base_priority   (s_base_priority),
        .s_target_pid      (s_target_pid),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_new_pid         (m_new_pid),
        .m_switched        (m_switched),
        .m_running_pid     (m_running_pid),
        .m_winning_priority(m_winning_priority)
    );

    function automatic sched_result_t table_step(sched_cmd_t c);
        sched_result_t              r;
        logic [bpts_pkg::WIN_W-1:0] best;
        logic [bpts_pkg::WIN_W-1:0] eff;
        int unsigned                best_pid;
        r        = '0;
        best     = '0;
        best_pid = 0;
        case (c.cmd)
            bpts_pkg::CMD_CREATE: begin
                if (threads_made < TABLE_DEPTH) begin
                    prio_table[threads_made] = c.prio;
                    live_mask[threads_made]  = 1'b1;
                    threads_made++;
                    r.new_pid = bpts_pkg::PID_W'(threads_made);
                end
            end
            bpts_pkg::CMD_TERMINATE: begin
                if (c.pid != 0 && c.pid <= threads_made) begin
                    live_mask[c.pid - 1] = 1'b0;
                end
            end
            bpts_pkg::CMD_SCHEDULE: begin
                if (sched_enabled) begin
                    for (int s = 0; s < threads_made; s++) begin
                        if (live_mask[s]) begin
                            eff = (prio_table[s] > bpts_pkg::BOOST_LIMIT)
                                  ? {1'b0, prio_table[s], 1'b0}
                                  : {2'b00, prio_table[s]};
                            eff = eff + bpts_pkg::FAIRNESS_TERM;
                            if (eff > best) begin
                                best     = eff;
                                best_pid = s + 1;
                            end
                        end
                    end
                    if (best_pid != 0) begin
                        r.win = best;
                        if (best_pid != current_pid) begin
                            r.switched  = 1'b1;
                            current_pid = best_pid;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        r.running_pid = bpts_pkg::PID_W'(current_pid);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        mismatches++;
        if (mismatches <= 40) begin
            $display("error at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
        end
    endtask

    // Prediction and checking share one process so that the oldest expectation
    // is always at the front when a result transaction is compared.
    always @(posedge aclk) begin : scoreboard
        sched_result_t want;
        if (aresetn) begin
            if (cfg_wr_en) begin
                sched_enabled = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(),
                                        table_step(sched_cmd_t'{s_command, s_base_priority,
                                                                s_target_pid}));
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, running_pid", 64'(m_running_pid),
                                    64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_new_pid !== want.new_pid) begin
                        report_mismatch("new_pid", 64'(m_new_pid), 64'(want.new_pid));
                    end
                    if (m_switched !== want.switched) begin
                        report_mismatch("switched", 64'(m_switched), 64'(want.switched));
                    end
                    if (m_running_pid !== want.running_pid) begin
                        report_mismatch("running_pid", 64'(m_running_pid),
                                        64'(want.running_pid));
                    end
                    if (m_winning_priority !== want.win) begin
                        report_mismatch("winning_priority", 64'(m_winning_priority),
                                        64'(want.win));
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : driver
        sched_cmd_t next_cmd;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                s_valid  <= 1'b0;
            end else if (pending_cmds.size() != 0) begin
                next_cmd = pending_cmds.pop_front();
                s_valid         <= 1'b1;
                s_command       <= next_cmd.cmd;
                s_base_priority <= next_cmd.prio;
                s_target_pid    <= next_cmd.pid;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 40);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // The result side stalls on a pattern taken from the top two bits of a free-running
    // cycle counter, and twice holds off for a long stretch so that the unit backs up.
    always @(posedge aclk) begin : receiver
        logic go;
        go = 1'b1;
        if (!aresetn) begin
            go = 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            go = 1'b0;
        end else if (m_valid && m_ready && (results_taken == 299 || results_taken == 899)) begin
            hold_left <= HOLD_CYCLES;
            go = 1'b0;
        end else begin
            case (rx_cycle[7:6])
                2'd0: go = 1'b1;
                2'd1: go = ($urandom_range(0, 1) == 1);
                2'd2: go = ($urandom_range(0, 3) == 0);
                default: go = (rx_cycle % 3 == 0);
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            results_taken <= results_taken + 1;
        end
        rx_cycle <= rx_cycle + 8'd1;
        m_ready  <= go;
    end

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("boosted_priority_thread_scheduler_unit: mismatch");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic queue_cmd(input logic [bpts_pkg::CMD_W-1:0] cmd,
                             input logic [bpts_pkg::PRIO_W-1:0] prio,
                             input logic [bpts_pkg::PID_W-1:0] pid);
        pending_cmds.insert(pending_cmds.size(), sched_cmd_t'{cmd, prio, pid});
        if (cmd == bpts_pkg::CMD_CREATE && gen_threads < TABLE_DEPTH) begin
            gen_threads++;
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic set_scheduler(input logic on);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= on;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic queue_random_cmd();
        int unsigned                 pick;
        logic [bpts_pkg::PRIO_W-1:0] prio;
        logic [bpts_pkg::PID_W-1:0]  pid;
        pick = $urandom_range(0, 99);
        pid  = bpts_pkg::PID_W'($urandom_range(0, 256));
        case ($urandom_range(0, 5))
            0: prio = $urandom_range(0, 20);
            1: prio = last_prio;
            2: prio = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
            3: prio = $urandom_range(9, 12);
            default: prio = $urandom;
        endcase
        if (pick < 30) begin
            last_prio = prio;
            queue_cmd(bpts_pkg::CMD_CREATE, prio, pid);
        end else if (pick < 45) begin
            if ($urandom_range(0, 4) != 0 && gen_threads != 0) begin
                pid = bpts_pkg::PID_W'($urandom_range(1, gen_threads));
            end
            queue_cmd(bpts_pkg::CMD_TERMINATE, prio, pid);
        end else if (pick < 94) begin
            queue_cmd(bpts_pkg::CMD_SCHEDULE, prio, pid);
        end else begin
            queue_cmd(bpts_pkg::CMD_RESERVED, prio, pid);
        end
    endtask

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Stopped scheduler with an empty table, unused code, bad pids.
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_RESERVED, 32'hFFFF_FFFF, 9'd256);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd1);
        set_scheduler(1'b1);

        // Running with no active entry, then boost edges, a tie and the maximum.
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_CREATE, 32'd0, 9'd0);
        queue_cmd(bpts_pkg::CMD_CREATE, 32'd10, 9'd0);
        queue_cmd(bpts_pkg::CMD_CREATE, 32'd11, 9'd0);
        queue_cmd(bpts_pkg::CMD_CREATE, 32'hFFFF_FFFF, 9'd0);
        queue_cmd(bpts_pkg::CMD_CREATE, 32'd11, 9'd0);
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd4);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd4);
        queue_cmd(bpts_pkg::CMD_RESERVED, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd6);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd256);
        queue_cmd(bpts_pkg::CMD_TERMINATE, 32'h0, 9'd3);
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        set_scheduler(1'b0);

        // Stopped scheduler with live entries.
        queue_cmd(bpts_pkg::CMD_SCHEDULE, 32'h0, 9'd0);
        queue_cmd(bpts_pkg::CMD_CREATE, 32'd5, 9'd0);
        set_scheduler(1'b1);

        for (int n = 0; n < 500; n++) begin
            queue_random_cmd();
        end
        set_scheduler(1'b0);
        for (int n = 0; n < 150; n++) begin
            queue_random_cmd();
        end
        set_scheduler(1'b1);
        for (int n = 0; n < 650; n++) begin
            queue_random_cmd();
        end

        wait_drained();
        repeat (END_SETTLE) @(negedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("boosted_priority_thread_scheduler_unit: match");
        end else begin
            $display("boosted_priority_thread_scheduler_unit: mismatch");
        end
        $finish;
    end

endmodule
